// File: rtl/bhl_pkg.sv
// Shared types, constants and sequencing codes for the barycentric height lookup.
`default_nettype none
package bhl_pkg;

	localparam int MAX_TRIANGLES = 256;

	localparam int COORD_W = 16;
	localparam int DIFF_W  = 17;
	localparam int AREA_W  = 37;
	localparam int PROD_W  = 54;
	localparam int REM_W   = 36;
	localparam int DIV_STEPS = PROD_W;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS);

	localparam logic [1:0] MODE_CLEAR  = 2'd0;
	localparam logic [1:0] MODE_APPEND = 2'd1;
	localparam logic [1:0] MODE_QUERY  = 2'd2;

	typedef struct packed {
		logic [1:0]         mode;
		logic signed [15:0] corner1_x;
		logic signed [15:0] corner1_y;
		logic signed [15:0] corner1_z;
		logic signed [15:0] corner2_x;
		logic signed [15:0] corner2_y;
		logic signed [15:0] corner2_z;
		logic signed [15:0] corner3_x;
		logic signed [15:0] corner3_y;
		logic signed [15:0] corner3_z;
		logic signed [15:0] point_x;
		logic signed [15:0] point_z;
	} req_t;

	typedef struct packed {
		logic signed [15:0] height;
		logic               found;
	} rsp_t;

	typedef struct packed {
		logic signed [15:0] z;
		logic signed [15:0] y;
		logic signed [15:0] x;
	} corner_t;

	typedef struct packed {
		corner_t c3;
		corner_t c2;
		corner_t c1;
	} tri_t;

	localparam int TRI_W = $bits(tri_t);

	typedef enum logic [3:0] {
		OP_NONE  = 4'd0,
		OP_QLOAD = 4'd1,
		OP_A0    = 4'd2,
		OP_A1    = 4'd3,
		OP_U0    = 4'd4,
		OP_U1    = 4'd5,
		OP_V0    = 4'd6,
		OP_V1    = 4'd7,
		OP_W     = 4'd8,
		OP_N0    = 4'd9,
		OP_N1    = 4'd10,
		OP_N2    = 4'd11,
		OP_DLOAD = 4'd12,
		OP_DSTEP = 4'd13,
		OP_RES   = 4'd14
	} op_t;

	typedef struct packed {
		op_t  op;
		logic found;
	} cmd_t;

	typedef struct packed {
		logic zero_area;
		logic hit;
	} stat_t;

endpackage
`default_nettype wire

// File: rtl/bhl_ram.sv
// Generic single-write, single-read RAM with a registered read port.
`default_nettype none
module bhl_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                                    clk,
	input  wire logic                                    we,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                        wdata,
	input  wire logic                                    re,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                             rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule
`default_nettype wire

// File: rtl/bhl_ctrl.sv
// Controller: table bookkeeping, triangle walk sequencing and result handshake.
`default_nettype none
module bhl_ctrl #(
	parameter int MAX_TRIANGLES = bhl_pkg::MAX_TRIANGLES,
	localparam int AW = (MAX_TRIANGLES > 1) ? $clog2(MAX_TRIANGLES) : 1,
	localparam int CW = $clog2(MAX_TRIANGLES + 1)
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           req_valid,
	input  wire logic [1:0]     req_mode,
	output logic                req_stall,
	output logic                rsp_valid,
	input  wire logic           rsp_stall,
	input  wire bhl_pkg::stat_t stat,
	output bhl_pkg::cmd_t       cmd,
	output logic                ram_we,
	output logic [AW-1:0]       ram_waddr,
	output logic                ram_re,
	output logic [AW-1:0]       ram_raddr
);
	typedef enum logic [15:0] {
		S_IDLE  = 16'h0001,
		S_FETCH = 16'h0002,
		S_A0    = 16'h0004,
		S_A1    = 16'h0008,
		S_U0    = 16'h0010,
		S_U1    = 16'h0020,
		S_V0    = 16'h0040,
		S_V1    = 16'h0080,
		S_W     = 16'h0100,
		S_CHK   = 16'h0200,
		S_N0    = 16'h0400,
		S_N1    = 16'h0800,
		S_N2    = 16'h1000,
		S_DLOAD = 16'h2000,
		S_DIV   = 16'h4000,
		S_DONE  = 16'h8000
	} state_t;

	state_t                        state_q, state_d;
	logic [CW-1:0]                 count_q, count_d;
	logic [CW-1:0]                 tri_q, tri_d;
	logic [bhl_pkg::DIV_CNT_W-1:0] div_q, div_d;
	logic                          found_q, found_d;
	logic                          rsp_valid_q, rsp_valid_d;
	logic                          accept;
	logic                          rsp_free;
	logic [CW-1:0]                 tri_next;

	assign accept    = req_valid && (state_q == S_IDLE);
	assign req_stall = (state_q != S_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp_free  = !rsp_valid_q || !rsp_stall;
	assign tri_next  = tri_q + CW'(1);
	assign ram_waddr = count_q[AW-1:0];
	assign ram_raddr = tri_q[AW-1:0];

	always_comb begin
		state_d     = state_q;
		count_d     = count_q;
		tri_d       = tri_q;
		div_d       = div_q;
		found_d     = found_q;
		rsp_valid_d = rsp_valid_q && rsp_stall;
		cmd.op      = bhl_pkg::OP_NONE;
		cmd.found   = found_q;
		ram_we      = 1'b0;
		ram_re      = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					case (req_mode)
						bhl_pkg::MODE_CLEAR: begin
							count_d = '0;
						end
						bhl_pkg::MODE_APPEND: begin
							if (count_q < CW'(MAX_TRIANGLES)) begin
								ram_we  = 1'b1;
								count_d = count_q + CW'(1);
							end
						end
						bhl_pkg::MODE_QUERY: begin
							cmd.op  = bhl_pkg::OP_QLOAD;
							tri_d   = '0;
							found_d = 1'b0;
							state_d = (count_q == '0) ? S_DONE : S_FETCH;
						end
						default: begin
						end
					endcase
				end
			end
			S_FETCH: begin
				ram_re  = 1'b1;
				state_d = S_A0;
			end
			S_A0: begin
				cmd.op  = bhl_pkg::OP_A0;
				state_d = S_A1;
			end
			S_A1: begin
				cmd.op  = bhl_pkg::OP_A1;
				state_d = S_U0;
			end
			S_U0: begin
				cmd.op  = bhl_pkg::OP_U0;
				state_d = S_U1;
			end
			S_U1: begin
				cmd.op  = bhl_pkg::OP_U1;
				state_d = S_V0;
			end
			S_V0: begin
				cmd.op  = bhl_pkg::OP_V0;
				state_d = S_V1;
			end
			S_V1: begin
				cmd.op  = bhl_pkg::OP_V1;
				state_d = S_W;
			end
			S_W: begin
				cmd.op  = bhl_pkg::OP_W;
				state_d = S_CHK;
			end
			S_CHK: begin
				if (stat.zero_area || !stat.hit) begin
					if (tri_next == count_q) begin
						state_d = S_DONE;
					end else begin
						tri_d   = tri_next;
						state_d = S_FETCH;
					end
				end else begin
					found_d = 1'b1;
					state_d = S_N0;
				end
			end
			S_N0: begin
				cmd.op  = bhl_pkg::OP_N0;
				state_d = S_N1;
			end
			S_N1: begin
				cmd.op  = bhl_pkg::OP_N1;
				state_d = S_N2;
			end
			S_N2: begin
				cmd.op  = bhl_pkg::OP_N2;
				state_d = S_DLOAD;
			end
			S_DLOAD: begin
				cmd.op  = bhl_pkg::OP_DLOAD;
				div_d   = '0;
				state_d = S_DIV;
			end
			S_DIV: begin
				cmd.op = bhl_pkg::OP_DSTEP;
				div_d  = div_q + bhl_pkg::DIV_CNT_W'(1);
				if (div_q == bhl_pkg::DIV_CNT_W'(bhl_pkg::DIV_STEPS - 1)) begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				if (rsp_free) begin
					cmd.op      = bhl_pkg::OP_RES;
					rsp_valid_d = 1'b1;
					state_d     = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			tri_q       <= '0;
			div_q       <= '0;
			found_q     <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			count_q     <= count_d;
			tri_q       <= tri_d;
			div_q       <= div_d;
			found_q     <= found_d;
			rsp_valid_q <= rsp_valid_d;
		end
	end
endmodule
`default_nettype wire

// File: rtl/bhl_dp.sv
// Datapath: shared multiplier, area and weight registers, serial divider, result register.
`default_nettype none
module bhl_dp (
	input  wire logic            clk,
	input  wire bhl_pkg::cmd_t   cmd,
	input  wire bhl_pkg::req_t   req,
	input  wire bhl_pkg::tri_t   tri_rd,
	output bhl_pkg::stat_t       stat,
	output bhl_pkg::rsp_t        rsp
);
	localparam int AW_ = bhl_pkg::AREA_W;
	localparam int PW  = bhl_pkg::PROD_W;
	localparam int RW  = bhl_pkg::REM_W;

	logic signed [15:0]   qx_q, qz_q;
	logic signed [AW_-1:0] a_q, u_q, v_q, w_q;
	logic signed [PW-1:0] acc_q;
	logic [PW-1:0]        n_q;
	logic [RW-1:0]        rem_q, d_q;
	logic                 neg_q;
	bhl_pkg::rsp_t        rsp_q;

	logic signed [AW_-1:0] mul_a;
	logic signed [bhl_pkg::DIFF_W-1:0] mul_b;
	logic signed [PW-1:0] prod;
	logic [RW-1:0]        rem_sh;
	logic                 rem_ge;
	logic [PW-1:0]        acc_abs;
	logic [AW_-1:0]       a_abs;
	logic signed [15:0]   height_sat;

	function automatic logic signed [bhl_pkg::DIFF_W-1:0] dif(
		input logic signed [15:0] p,
		input logic signed [15:0] q
	);
		return bhl_pkg::DIFF_W'(p) - bhl_pkg::DIFF_W'(q);
	endfunction

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (cmd.op)
			bhl_pkg::OP_A0: begin
				mul_a = AW_'(dif(tri_rd.c2.x, tri_rd.c1.x));
				mul_b = dif(tri_rd.c3.z, tri_rd.c1.z);
			end
			bhl_pkg::OP_A1: begin
				mul_a = AW_'(dif(tri_rd.c3.x, tri_rd.c1.x));
				mul_b = dif(tri_rd.c2.z, tri_rd.c1.z);
			end
			bhl_pkg::OP_U0: begin
				mul_a = AW_'(dif(tri_rd.c2.x, qx_q));
				mul_b = dif(tri_rd.c3.z, qz_q);
			end
			bhl_pkg::OP_U1: begin
				mul_a = AW_'(dif(tri_rd.c3.x, qx_q));
				mul_b = dif(tri_rd.c2.z, qz_q);
			end
			bhl_pkg::OP_V0: begin
				mul_a = AW_'(dif(tri_rd.c3.x, qx_q));
				mul_b = dif(tri_rd.c1.z, qz_q);
			end
			bhl_pkg::OP_V1: begin
				mul_a = AW_'(dif(tri_rd.c1.x, qx_q));
				mul_b = dif(tri_rd.c3.z, qz_q);
			end
			bhl_pkg::OP_N0: begin
				mul_a = u_q;
				mul_b = bhl_pkg::DIFF_W'(tri_rd.c1.y);
			end
			bhl_pkg::OP_N1: begin
				mul_a = v_q;
				mul_b = bhl_pkg::DIFF_W'(tri_rd.c2.y);
			end
			bhl_pkg::OP_N2: begin
				mul_a = w_q;
				mul_b = bhl_pkg::DIFF_W'(tri_rd.c3.y);
			end
			default: begin
			end
		endcase
	end

	assign prod = PW'(mul_a) * PW'(mul_b);

	assign acc_abs = acc_q[PW-1] ? PW'(-acc_q) : PW'(acc_q);
	assign a_abs   = a_q[AW_-1] ? AW_'(-a_q) : AW_'(a_q);
	assign rem_sh  = {rem_q[RW-2:0], n_q[PW-1]};
	assign rem_ge  = (rem_sh >= d_q);

	// Magnitude of the quotient never exceeds a corner height for a real hit.
	always_comb begin
		if (neg_q) begin
			height_sat = (n_q > PW'(32768)) ? 16'sh8000 : 16'(-n_q[15:0]);
		end else begin
			height_sat = (n_q > PW'(32767)) ? 16'sh7fff : 16'(n_q[15:0]);
		end
	end

	assign stat.zero_area = (a_q == '0);
	assign stat.hit = a_q[AW_-1]
		? ((u_q <= 0) && (v_q <= 0) && (w_q <= 0))
		: ((u_q >= 0) && (v_q >= 0) && (w_q >= 0));

	always_ff @(posedge clk) begin
		case (cmd.op)
			bhl_pkg::OP_QLOAD: begin
				qx_q <= req.point_x;
				qz_q <= req.point_z;
			end
			bhl_pkg::OP_A0, bhl_pkg::OP_U0, bhl_pkg::OP_V0, bhl_pkg::OP_N0: begin
				acc_q <= prod;
			end
			bhl_pkg::OP_A1: begin
				a_q <= AW_'(acc_q - prod);
			end
			bhl_pkg::OP_U1: begin
				u_q <= AW_'(acc_q - prod);
			end
			bhl_pkg::OP_V1: begin
				v_q <= AW_'(acc_q - prod);
			end
			bhl_pkg::OP_W: begin
				w_q <= a_q - u_q - v_q;
			end
			bhl_pkg::OP_N1, bhl_pkg::OP_N2: begin
				acc_q <= acc_q + prod;
			end
			bhl_pkg::OP_DLOAD: begin
				n_q   <= acc_abs;
				d_q   <= RW'(a_abs);
				rem_q <= '0;
				neg_q <= acc_q[PW-1] ^ a_q[AW_-1];
			end
			bhl_pkg::OP_DSTEP: begin
				rem_q <= rem_ge ? (rem_sh - d_q) : rem_sh;
				n_q   <= {n_q[PW-2:0], rem_ge};
			end
			bhl_pkg::OP_RES: begin
				rsp_q.found  <= cmd.found;
				rsp_q.height <= cmd.found ? height_sat : 16'sd0;
			end
			default: begin
			end
		endcase
	end

	assign rsp = rsp_q;
endmodule
`default_nettype wire

// File: rtl/barycentric_height_lookup.sv
// Top level of the barycentric terrain height lookup.
`default_nettype none
// Usage:
// The req channel takes one word per command: clear the triangle table, append
// a triangle (three corners x, y, z in Q8.8), or query the height at a point.
// Clear and append finish in the cycle they are accepted and give no result, so
// they can follow each other every cycle. Appends into a full table are dropped.
// A query walks the stored triangles in load order; each takes one RAM read,
// six steps of the shared multiplier, the third weight and the check. The first
// containing triangle adds the weighted sum of its corner heights on the shared
// multiplier, one divider load and a restoring divide of the 54-bit numerator;
// req_stall stays high from the accepting edge until the word is in the output
// register.
// The rsp channel carries height and found through an output register. While
// the receiver stalls, clears and appends are still taken; a second query
// finishes its walk and then waits until the held word is taken.
// Reset empties the table and drops any pending word; stored corners are not
// cleared, since only entries written since the last clear are read.
module barycentric_height_lookup #(
	parameter int MAX_TRIANGLES = bhl_pkg::MAX_TRIANGLES,
	localparam int AW = (MAX_TRIANGLES > 1) ? $clog2(MAX_TRIANGLES) : 1
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          req_valid,
	output logic               req_stall,
	input  wire bhl_pkg::req_t req,
	output logic               rsp_valid,
	input  wire logic          rsp_stall,
	output bhl_pkg::rsp_t      rsp
);
	bhl_pkg::cmd_t  cmd;
	bhl_pkg::stat_t stat;
	bhl_pkg::tri_t  tri_wr, tri_rd;
	logic           ram_we, ram_re;
	logic [AW-1:0]  ram_waddr, ram_raddr;

	assign tri_wr.c1 = '{z: req.corner1_z, y: req.corner1_y, x: req.corner1_x};
	assign tri_wr.c2 = '{z: req.corner2_z, y: req.corner2_y, x: req.corner2_x};
	assign tri_wr.c3 = '{z: req.corner3_z, y: req.corner3_y, x: req.corner3_x};

	bhl_ctrl #(.MAX_TRIANGLES(MAX_TRIANGLES)) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_mode  (req.mode),
		.req_stall (req_stall),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.stat      (stat),
		.cmd       (cmd),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_re    (ram_re),
		.ram_raddr (ram_raddr)
	);

	bhl_ram #(.WIDTH(bhl_pkg::TRI_W), .DEPTH(MAX_TRIANGLES)) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (tri_wr),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (tri_rd)
	);

	bhl_dp u_dp (
		.clk    (clk),
		.cmd    (cmd),
		.req    (req),
		.tri_rd (tri_rd),
		.stat   (stat),
		.rsp    (rsp)
	);
endmodule
`default_nettype wire

// File: rtl/bhl_checker.sv
// Port-level checker for the height lookup, bound to the top level.
`default_nettype none
module bhl_checker (
	input wire logic          clk,
	input wire logic          arst_n,
	input wire logic          req_valid,
	input wire logic          req_stall,
	input wire bhl_pkg::req_t req,
	input wire logic          rsp_valid,
	input wire logic          rsp_stall,
	input wire bhl_pkg::rsp_t rsp
);
	logic [1:0] pend_q;
	logic       q_acc, r_acc;

	assign q_acc = req_valid && !req_stall && (req.mode == bhl_pkg::MODE_QUERY);
	assign r_acc = rsp_valid && !rsp_stall;

	// Queries accepted whose word has not yet been taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else begin
			pend_q <= pend_q + 2'(q_acc) - 2'(r_acc);
		end
	end

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("response word changed while stalled");

	a_no_extra: assert property (@(posedge clk) disable iff (!arst_n)
		r_acc |-> (pend_q != 2'd0))
		else $error("response word without a query");

	a_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q <= 2'd2)
		else $error("more than two queries outstanding");

	a_query_busy: assert property (@(posedge clk) disable iff (!arst_n)
		q_acc |=> req_stall)
		else $error("request taken right after a query");
endmodule

bind barycentric_height_lookup bhl_checker u_bhl_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_stall (req_stall),
	.req       (req),
	.rsp_valid (rsp_valid),
	.rsp_stall (rsp_stall),
	.rsp       (rsp)
);
`default_nettype wire

// File: tb/sv/barycentric_height_lookup_tb.sv
// Self-checking testbench for the barycentric height lookup: predicts query results and compares.
`default_nettype none
module barycentric_height_lookup_tb;

	localparam int LIMIT = 4000000;
	localparam int HOLD_CYCLES = 3000;
	localparam int REQ_W = $bits(bhl_pkg::req_t);
	localparam logic [1:0] MODE_UNUSED = 2'd3;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	bhl_pkg::req_t req = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	bhl_pkg::rsp_t rsp;

	barycentric_height_lookup DUT (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_stall(req_stall), .req(req),
		.rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp)
	);

	always #2 clk = ~clk;

	// Predictor state: the triangle table as the block should hold it.
	bhl_pkg::tri_t terrain[bhl_pkg::MAX_TRIANGLES];
	int unsigned tri_count = 0;

	bhl_pkg::req_t pending_words[$];
	bhl_pkg::rsp_t expected_heights[$];
	int errors = 0;
	int cycles = 0;
	bit calm = 1'b0;
	bit hold_req = 1'b0;
	bit hold_done = 1'b0;
	int hold_cnt = 0;
	bit pause_sender = 1'b0;
	int req_gap = 0;
	int rsp_gap = 0;

	// Acceptance flag sampled at the rising edge.
	bit req_taken = 1'b0;

	function automatic bhl_pkg::rsp_t height_at(input logic signed [15:0] qx,
		input logic signed [15:0] qz);
		bhl_pkg::rsp_t r;
		longint x1, z1, x2, z2, x3, z3, a, u, v, w, num, h;
		r = '0;
		for (int t = 0; t < tri_count; t++) begin
			x1 = terrain[t].c1.x; z1 = terrain[t].c1.z;
			x2 = terrain[t].c2.x; z2 = terrain[t].c2.z;
			x3 = terrain[t].c3.x; z3 = terrain[t].c3.z;
			a = (x2 - x1) * (z3 - z1) - (x3 - x1) * (z2 - z1);
			if (a == 0)
				continue;
			u = (x2 - qx) * (z3 - qz) - (x3 - qx) * (z2 - qz);
			v = (x3 - qx) * (z1 - qz) - (x1 - qx) * (z3 - qz);
			w = a - u - v;
			if (a > 0 ? (u >= 0 && v >= 0 && w >= 0) : (u <= 0 && v <= 0 && w <= 0)) begin
				num = u * terrain[t].c1.y + v * terrain[t].c2.y + w * terrain[t].c3.y;
				h = num / a;
				if (h > 32767) h = 32767;
				if (h < -32768) h = -32768;
				r.height = h[15:0];
				r.found = 1'b1;
				return r;
			end
		end
		return r;
	endfunction

	task automatic apply_word(input bhl_pkg::req_t w);
		if (w.mode == bhl_pkg::MODE_CLEAR) begin
			tri_count = 0;
		end else if (w.mode == bhl_pkg::MODE_APPEND) begin
			if (tri_count < bhl_pkg::MAX_TRIANGLES) begin
				terrain[tri_count] = {w.corner3_z, w.corner3_y, w.corner3_x,
					w.corner2_z, w.corner2_y, w.corner2_x,
					w.corner1_z, w.corner1_y, w.corner1_x};
				tri_count++;
			end
		end else if (w.mode == bhl_pkg::MODE_QUERY) begin
			expected_heights.push_back(height_at(w.point_x, w.point_z));
		end
	endtask

	// Receiver hold-off length is counted here, once requested.
	always @(posedge clk) begin
		if (hold_req && !hold_done) begin
			if (hold_cnt == HOLD_CYCLES - 1)
				hold_done <= 1'b1;
			else
				hold_cnt <= hold_cnt + 1;
		end
	end

	// Driver: changes inputs on the falling edge.
	always @(negedge clk) begin
		if (arst_n) begin
			if (!req_valid || req_taken) begin
				if (req_gap > 0 || pause_sender || pending_words.size() == 0) begin
					req_valid <= 1'b0;
					if (req_gap > 0)
						req_gap--;
				end else begin
					req <= pending_words.pop_front();
					req_valid <= 1'b1;
					if (!calm && $urandom_range(0, 5) == 0)
						req_gap = $urandom_range(1, 5);
				end
			end
			if (hold_req && !hold_done) begin
				rsp_stall <= 1'b1;
			end else if (rsp_gap > 0) begin
				rsp_stall <= 1'b1;
				rsp_gap--;
			end else if (!calm && $urandom_range(0, 5) == 0) begin
				rsp_stall <= 1'b1;
				rsp_gap = $urandom_range(0, 4);
			end else begin
				rsp_stall <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		req_taken = req_valid && !req_stall;
		if (req_taken)
			apply_word(req);
		if (rsp_valid && !rsp_stall) begin
			if (expected_heights.size() == 0) begin
				$display("%0t: unexpected word height=%0d found=%0b", $time, rsp.height, rsp.found);
				errors++;
			end else begin
				bhl_pkg::rsp_t e;
				e = expected_heights.pop_front();
				if (rsp.height !== e.height || rsp.found !== e.found) begin
					$display("%0t: mismatch expected height=%0d found=%0b actual height=%0d found=%0b",
						$time, e.height, e.found, rsp.height, rsp.found);
					errors++;
				end
			end
		end
		if (cycles > LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	function automatic logic signed [15:0] rnd16();
		case ($urandom_range(0, 5))
			0: return 16'sh7fff;
			1: return 16'sh8000;
			2: return 16'sd0;
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic bhl_pkg::req_t mk(input logic [1:0] m);
		bhl_pkg::req_t w;
		w = REQ_W'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
		w.mode = m;
		return w;
	endfunction

	function automatic bhl_pkg::req_t tri_word(input int x1, z1, y1, x2, z2, y2, x3, z3, y3);
		bhl_pkg::req_t w;
		w = mk(bhl_pkg::MODE_APPEND);
		w.corner1_x = 16'(x1); w.corner1_z = 16'(z1); w.corner1_y = 16'(y1);
		w.corner2_x = 16'(x2); w.corner2_z = 16'(z2); w.corner2_y = 16'(y2);
		w.corner3_x = 16'(x3); w.corner3_z = 16'(z3); w.corner3_y = 16'(y3);
		return w;
	endfunction

	function automatic bhl_pkg::req_t query(input int qx, qz);
		bhl_pkg::req_t w;
		w = mk(bhl_pkg::MODE_QUERY);
		w.point_x = 16'(qx);
		w.point_z = 16'(qz);
		return w;
	endfunction

	task automatic wait_drained();
		while (pending_words.size() != 0 || req_valid || expected_heights.size() != 0)
			@(posedge clk);
	endtask

	// A random triangle near a center so that queries often land inside it.
	function automatic bhl_pkg::req_t near_tri(input int cx, cz, input int span);
		return tri_word(cx + $urandom_range(0, span) - span / 2, cz + $urandom_range(0, span) - span / 2,
			rnd16(), cx + $urandom_range(0, span) - span / 2, cz + $urandom_range(0, span) - span / 2,
			rnd16(), cx + $urandom_range(0, span) - span / 2, cz + $urandom_range(0, span) - span / 2,
			rnd16());
	endfunction

	initial begin
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: empty table, edges, corners, zero area, extremes, unused mode.
		pending_words.push_back(query(0, 0));
		pending_words.push_back(tri_word(0, 0, 0, 0, 0, 0, 0, 0, 0));
		pending_words.push_back(query(0, 0));
		pending_words.push_back(tri_word(0, 0, 256, 1024, 0, -512, 0, 1024, 32767));
		pending_words.push_back(query(0, 0));
		pending_words.push_back(query(512, 0));
		pending_words.push_back(query(100, 100));
		pending_words.push_back(query(2000, 2000));
		pending_words.push_back(tri_word(-32768, -32768, -32768, 32767, -32768, 32767,
			-32768, 32767, -32768));
		pending_words.push_back(query(-32768, 32767));
		pending_words.push_back(query(32767, 32767));
		pending_words.push_back(query(-100, -200));
		pending_words.push_back(mk(MODE_UNUSED));
		pending_words.push_back(query(10, 10));
		pending_words.push_back(mk(bhl_pkg::MODE_CLEAR));
		pending_words.push_back(query(10, 10));
		pending_words.push_back(tri_word(0, 0, 5, 0, 100, 6, 100, 0, 7));
		pending_words.push_back(query(10, 10));
		pending_words.push_back(mk(bhl_pkg::MODE_QUERY));
		wait_drained();

		// Receiver holds off while the sender keeps offering.
		for (int i = 0; i < 6; i++) begin
			pending_words.push_back(near_tri(0, 0, 400));
			pending_words.push_back(query($urandom_range(0, 200) - 100, $urandom_range(0, 200) - 100));
		end
		hold_req = 1'b1;
		while (!hold_done)
			@(posedge clk);
		hold_req = 1'b0;
		wait_drained();

		// Random phases of small tables; the last phase runs without gaps.
		for (int p = 0; p < 5; p++) begin
			int n;
			if (p == 4)
				calm = 1'b1;
			pending_words.push_back(mk(bhl_pkg::MODE_CLEAR));
			n = $urandom_range(1, 6);
			for (int i = 0; i < n; i++)
				pending_words.push_back($urandom_range(0, 7) == 0 ? mk(bhl_pkg::MODE_APPEND) :
					near_tri($urandom_range(0, 800) - 400, $urandom_range(0, 800) - 400, 900));
			for (int i = 0; i < 10; i++) begin
				if ($urandom_range(0, 9) == 0)
					pending_words.push_back(mk($urandom_range(0, 9) == 0 ? MODE_UNUSED :
						bhl_pkg::MODE_APPEND));
				else if ($urandom_range(0, 9) == 0)
					pending_words.push_back(mk(bhl_pkg::MODE_QUERY));
				else
					pending_words.push_back(query($urandom_range(0, 1200) - 600,
						$urandom_range(0, 1200) - 600));
			end
			if (p == 2) begin
				// Sender pauses with words still queued until every expected word has come back.
				while (expected_heights.size() == 0 && pending_words.size() != 0)
					@(posedge clk);
				pause_sender = 1'b1;
				while (expected_heights.size() != 0)
					@(posedge clk);
				pause_sender = 1'b0;
			end
		end
		wait_drained();
		repeat (100) @(posedge clk);
		if (errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end
endmodule
`default_nettype wire
